[rtl/core/expression_tokenizer_unit_assert.svh]
// Assertion macros shared by the tokenizer RTL.
`ifndef EXPRESSION_TOKENIZER_UNIT_ASSERT_SVH
`define EXPRESSION_TOKENIZER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a condition at every clock edge outside reset.
`define ETU_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Check that a condition in one cycle implies another in the next.
`define ETU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ETU_ASSERT_ALWAYS(label, cond, msg)
`define ETU_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/core/etu_pkg.sv]
// Package: token kinds, character codes, token word type and character classes.
`timescale 1ns / 1ps
package etu_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int TOKQ_DEPTH      = 4;

	// Token kinds
	localparam logic [3:0] KIND_NUMBER  = 4'd0;
	localparam logic [3:0] KIND_IDENT   = 4'd1;
	localparam logic [3:0] KIND_PLUS    = 4'd2;
	localparam logic [3:0] KIND_MINUS   = 4'd3;
	localparam logic [3:0] KIND_STAR    = 4'd4;
	localparam logic [3:0] KIND_SLASH   = 4'd5;
	localparam logic [3:0] KIND_CARET   = 4'd6;
	localparam logic [3:0] KIND_LPAREN  = 4'd7;
	localparam logic [3:0] KIND_RPAREN  = 4'd8;
	localparam logic [3:0] KIND_BAR     = 4'd9;
	localparam logic [3:0] KIND_COMMA   = 4'd10;
	localparam logic [3:0] KIND_INVALID = 4'd11;
	localparam logic [3:0] KIND_END     = 4'd12;

	// Character codes
	localparam logic [7:0] CH_END    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [15:0] line;
		logic [15:0] column;
		logic [7:0]  tbyte;
		logic        last;
	} token_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic [3:0] operator_kind(input logic [7:0] c);
		logic [3:0] k;
		unique case (c)
			CH_PLUS:   k = KIND_PLUS;
			CH_MINUS:  k = KIND_MINUS;
			CH_STAR:   k = KIND_STAR;
			CH_SLASH:  k = KIND_SLASH;
			CH_CARET:  k = KIND_CARET;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_BAR:    k = KIND_BAR;
			CH_COMMA:  k = KIND_COMMA;
			default:   k = KIND_INVALID;
		endcase
		return k;
	endfunction

endpackage

[rtl/core/etu_char_if.sv]
// Interface: character channel, one byte per word.
`timescale 1ns / 1ps
interface etu_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface

[rtl/core/etu_token_if.sv]
// Interface: token channel, one token per word.
`timescale 1ns / 1ps
interface etu_token_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [15:0] token_line;
	logic [15:0] token_column;
	logic [7:0]  token_byte;
	logic        last_of_run;

	modport source (
		output valid, output token_kind, output token_start, output token_length,
		output token_line, output token_column, output token_byte,
		output last_of_run, input ready
	);
	modport sink (
		input valid, input token_kind, input token_start, input token_length,
		input token_line, input token_column, input token_byte,
		input last_of_run, output ready
	);
endinterface

[rtl/core/expression_tokenizer_unit.sv]
// Top level: streaming lexer for arithmetic expressions.
`timescale 1ns / 1ps
`include "expression_tokenizer_unit_assert.svh"
// Usage
//   chars  : sink channel, one character byte per word; byte 0 marks end of input.
//   tokens : source channel, one token per word (kind, start offset, length,
//            line, column, character, last_of_run).
//   A byte gives zero, one or two tokens; last_of_run marks the final token
//   that a byte causes. An end byte flushes any pending number or identifier,
//   then gives the end token and returns all counters to their start values.
//
// Timing
//   A byte is registered in the input stage at acceptance and then classified,
//   which writes its tokens into a four-entry token queue once two entries
//   are free; tokens are offered from the head of that queue.
//   One byte per cycle is taken while the receiver keeps pace; a byte that
//   gives two tokens needs two output words, and the token queue depth sets
//   how long the input keeps flowing across such bursts.
//
// Reset and stall
//   arst_n clears scan state, counters, the input stage and the token queue.
//   When the receiver stalls, tokens hold in the queue; once fewer than two
//   entries are free, the input stage holds its byte and ready drops.
module expression_tokenizer_unit #(
	parameter int COUNT_WIDTH = etu_pkg::COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	etu_char_if.sink           chars,
	etu_token_if.source        tokens
);
	import etu_pkg::*;

	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_NUMBER = 2'd1;
	localparam logic [1:0] MODE_IDENT  = 2'd2;

	localparam int EXT_W  = COUNT_WIDTH + 16;
	localparam int QPTR_W = $clog2(TOKQ_DEPTH);
	localparam int QCNT_W = $clog2(TOKQ_DEPTH + 1);
	localparam logic [QCNT_W-1:0] QROOM_MAX = QCNT_W'(TOKQ_DEPTH - 2);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

	// Low 16 bits of a counter, zero-extended when the counter is narrower.
	function automatic logic [15:0] low16(input logic [COUNT_WIDTH-1:0] v);
		logic [EXT_W-1:0] e;
		e = {16'b0, v};
		return e[15:0];
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_ONE;
	endfunction

	// ---------------------------------------------------------------- input stage
	logic       s1_valid_q;
	logic [7:0] char_s1;
	logic       s1_go;
	logic       q_room;

	assign s1_go       = s1_valid_q && q_room;
	assign chars.ready = !s1_valid_q || q_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (chars.ready) begin
			s1_valid_q <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_byte;
		end
	end

	// ---------------------------------------------------------------- scan state
	logic [1:0]             mode_q;
	logic                   dot_q;
	logic [COUNT_WIDTH-1:0] pos_q;
	logic [COUNT_WIDTH-1:0] line_q;
	logic [COUNT_WIDTH-1:0] col_q;
	logic [COUNT_WIDTH-1:0] pstart_q;
	logic [COUNT_WIDTH-1:0] pline_q;
	logic [COUNT_WIDTH-1:0] pcol_q;

	// ---------------------------------------------------------------- classify
	logic                   c_digit, c_letter, c_space, c_dot, c_end, c_nl, c_uscore;
	logic                   absorb, flush, own_emit, start_num, start_id;
	logic [COUNT_WIDTH-1:0] plen;
	logic [COUNT_WIDTH-1:0] pos_adv, line_adv, col_adv;
	token_t                 pend_tok, own_tok, first_tok;
	logic [1:0]             push_n;

	always_comb begin
		c_digit  = is_digit(char_s1);
		c_letter = is_letter(char_s1);
		c_space  = is_space(char_s1);
		c_dot    = (char_s1 == CH_DOT);
		c_end    = (char_s1 == CH_END);
		c_nl     = (char_s1 == CH_NL);
		c_uscore = (char_s1 == CH_USCORE);

		// Extend the pending token, or end it and handle the byte from idle.
		absorb = ((mode_q == MODE_NUMBER) && (c_digit || (c_dot && !dot_q)))
			|| ((mode_q == MODE_IDENT) && (c_letter || c_digit || c_uscore));
		flush     = (mode_q != MODE_IDLE) && !absorb;
		start_num = !absorb && (c_digit || c_dot);
		start_id  = !absorb && c_letter;
		own_emit  = !absorb && (c_end || !(c_space || c_digit || c_dot || c_letter));

		plen = (pos_q >= pstart_q) ? pos_q - pstart_q : CNT_ZERO;

		pend_tok.kind   = (mode_q == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
		pend_tok.start  = low16(pstart_q);
		pend_tok.length = low16(plen);
		pend_tok.line   = low16(pline_q);
		pend_tok.column = low16(pcol_q);
		pend_tok.tbyte  = 8'h00;
		pend_tok.last   = 1'b0;

		own_tok.kind   = c_end ? KIND_END : operator_kind(char_s1);
		own_tok.start  = low16(pos_q);
		own_tok.length = c_end ? 16'd0 : 16'd1;
		own_tok.line   = low16(line_q);
		own_tok.column = low16(col_q);
		own_tok.tbyte  = c_end ? 8'h00 : char_s1;
		own_tok.last   = 1'b1;

		// The first slot gets the flushed token when there is one.
		first_tok      = flush ? pend_tok : own_tok;
		first_tok.last = !(flush && own_emit);

		push_n = s1_go ? ({1'b0, flush} + {1'b0, own_emit}) : 2'd0;

		pos_adv  = sat_inc(pos_q);
		line_adv = c_nl ? sat_inc(line_q) : line_q;
		col_adv  = c_nl ? CNT_ONE : sat_inc(col_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			dot_q    <= 1'b0;
			pos_q    <= CNT_ZERO;
			line_q   <= CNT_ONE;
			col_q    <= CNT_ONE;
			pstart_q <= CNT_ZERO;
			pline_q  <= CNT_ONE;
			pcol_q   <= CNT_ONE;
		end else if (s1_go) begin
			if (absorb) begin
				// Extend the pending token.
				if (c_dot) begin
					dot_q <= 1'b1;
				end
				pos_q  <= pos_adv;
				line_q <= line_adv;
				col_q  <= col_adv;
			end else if (c_end) begin
				// Drop back to the start state after the end token.
				mode_q   <= MODE_IDLE;
				dot_q    <= 1'b0;
				pos_q    <= CNT_ZERO;
				line_q   <= CNT_ONE;
				col_q    <= CNT_ONE;
				pstart_q <= CNT_ZERO;
				pline_q  <= CNT_ONE;
				pcol_q   <= CNT_ONE;
			end else begin
				if (start_num) begin
					mode_q <= MODE_NUMBER;
				end else if (start_id) begin
					mode_q <= MODE_IDENT;
				end else begin
					mode_q <= MODE_IDLE;
				end
				dot_q <= start_num && c_dot;
				if (start_num || start_id) begin
					pstart_q <= pos_q;
					pline_q  <= line_q;
					pcol_q   <= col_q;
				end
				pos_q  <= pos_adv;
				line_q <= line_adv;
				col_q  <= col_adv;
			end
		end
	end

	// ---------------------------------------------------------------- token queue
	token_t              q_mem [TOKQ_DEPTH];
	logic [QPTR_W-1:0]   wp_q, rp_q;
	logic [QCNT_W-1:0]   qcnt_q;
	logic                pop;
	logic [QPTR_W-1:0]   wp_next1;
	token_t              head;

	assign q_room   = (qcnt_q <= QROOM_MAX);
	assign pop      = tokens.valid && tokens.ready;
	assign wp_next1 = wp_q + QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			q_mem[wp_q] <= first_tok;
		end
		if (push_n == 2'd2) begin
			q_mem[wp_next1] <= own_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			qcnt_q <= '0;
		end else begin
			wp_q   <= wp_q + QPTR_W'(push_n);
			if (pop) begin
				rp_q <= rp_q + QPTR_W'(1);
			end
			qcnt_q <= qcnt_q + QCNT_W'(push_n) - QCNT_W'(pop);
		end
	end

	assign head                = q_mem[rp_q];
	assign tokens.valid        = (qcnt_q != '0);
	assign tokens.token_kind   = head.kind;
	assign tokens.token_start  = head.start;
	assign tokens.token_length = head.length;
	assign tokens.token_line   = head.line;
	assign tokens.token_column = head.column;
	assign tokens.token_byte   = head.tbyte;
	assign tokens.last_of_run  = head.last;

	// ---------------------------------------------------------------- checks
	`ETU_ASSERT_ALWAYS(a_queue_bound, qcnt_q <= QCNT_W'(TOKQ_DEPTH), "token queue overflow")
	`ETU_ASSERT_ALWAYS(a_dot_in_number, !dot_q || (mode_q == MODE_NUMBER), "dot flag outside number")
	`ETU_ASSERT_ALWAYS(a_line_nonzero, line_q != CNT_ZERO, "line counter reached zero")
	`ETU_ASSERT_NEXT(a_end_clears, s1_go && c_end, (pos_q == CNT_ZERO) && (mode_q == MODE_IDLE), "end byte left state")
	`ETU_ASSERT_NEXT(a_stage_holds, s1_valid_q && !q_room, s1_valid_q && $stable(char_s1), "input stage lost a byte")

endmodule

[test/tb_top.sv]
// Testbench for the expression tokenizer: byte stream in, token words checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
	import etu_pkg::*;

	// Cycles the receiver refuses words during its long hold-off.
	localparam int LONG_HOLD   = 500;
	// Cycles without any accepted word before the run is declared hung.
	localparam int QUIET_LIMIT = 4000;
	// Cycles to wait after the last expected token, to catch stray words.
	localparam int TAIL_CYCLES = 20;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_IDENT} scan_state_t;
	typedef enum logic [2:0] {
		CLS_END, CLS_SPACE, CLS_DIGIT, CLS_DOT, CLS_LETTER, CLS_USCORE, CLS_OTHER
	} char_class_t;

	logic clk = 1'b0;
	logic arst_n;

	etu_char_if  char_bus ();
	etu_token_if token_bus ();

	expression_tokenizer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (char_bus),
		.tokens (token_bus)
	);

	always #5 clk = ~clk;

	// Bytes still to send, and tokens the lexer is expected to produce.
	logic [7:0] char_q[$];
	token_t     token_expect_q[$];

	// Append one byte to the send queue.
	task automatic queue_byte(input logic [7:0] c);
		char_q.insert(char_q.size(), c);
	endtask

	// Controls set by the sequencer at falling edges.
	bit idle_on = 1'b1;
	int stall_requests = 0;

	int mismatch_count = 0;

	// Lexer state mirror.
	scan_state_t scan_st;
	bit          saw_dot;
	logic [15:0] pos_cnt;
	logic [15:0] line_cnt;
	logic [15:0] col_cnt;
	logic [15:0] open_start;
	logic [15:0] open_line;
	logic [15:0] open_col;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == COUNT_MAX) ? v : v + 16'd1;
	endfunction

	function automatic char_class_t classify(input logic [7:0] c);
		if (c == CH_END) return CLS_END;
		if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return CLS_SPACE;
		if (c >= CH_ZERO && c <= CH_NINE) return CLS_DIGIT;
		if (c == CH_DOT) return CLS_DOT;
		if ((c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ)) return CLS_LETTER;
		if (c == CH_USCORE) return CLS_USCORE;
		return CLS_OTHER;
	endfunction

	function automatic logic [3:0] single_kind(input logic [7:0] c);
		case (c)
			CH_PLUS:   return KIND_PLUS;
			CH_MINUS:  return KIND_MINUS;
			CH_STAR:   return KIND_STAR;
			CH_SLASH:  return KIND_SLASH;
			CH_CARET:  return KIND_CARET;
			CH_LPAREN: return KIND_LPAREN;
			CH_RPAREN: return KIND_RPAREN;
			CH_BAR:    return KIND_BAR;
			CH_COMMA:  return KIND_COMMA;
			default:   return KIND_INVALID;
		endcase
	endfunction

	task automatic clear_lexer();
		scan_st    = SCAN_IDLE;
		saw_dot    = 1'b0;
		pos_cnt    = 16'd0;
		line_cnt   = 16'd1;
		col_cnt    = 16'd1;
		open_start = 16'd0;
		open_line  = 16'd1;
		open_col   = 16'd1;
	endtask

	// Consume one byte: advance position, and line or column.
	task automatic step_counters(input logic [7:0] c);
		pos_cnt = sat_inc(pos_cnt);
		if (c == CH_NL) begin
			line_cnt = sat_inc(line_cnt);
			col_cnt  = 16'd1;
		end else begin
			col_cnt = sat_inc(col_cnt);
		end
	endtask

	task automatic open_token(input scan_state_t st);
		scan_st    = st;
		open_start = pos_cnt;
		open_line  = line_cnt;
		open_col   = col_cnt;
	endtask

	// Work out the tokens one accepted byte gives and queue them in order.
	task automatic lex_byte(input logic [7:0] c);
		char_class_t cls;
		token_t      made[2];
		int          n;
		int          i;
		cls = classify(c);
		n = 0;
		// Extend a pending number or identifier; no token.
		if (scan_st == SCAN_NUMBER &&
		    (cls == CLS_DIGIT || (cls == CLS_DOT && !saw_dot))) begin
			if (cls == CLS_DOT) saw_dot = 1'b1;
			step_counters(c);
			return;
		end
		if (scan_st == SCAN_IDENT &&
		    (cls == CLS_LETTER || cls == CLS_DIGIT || cls == CLS_USCORE)) begin
			step_counters(c);
			return;
		end
		// Any other byte closes the pending token first.
		if (scan_st != SCAN_IDLE) begin
			made[n].kind   = (scan_st == SCAN_NUMBER) ? KIND_NUMBER : KIND_IDENT;
			made[n].start  = open_start;
			// Length stops growing once the position counter has saturated.
			made[n].length = (pos_cnt >= open_start) ? pos_cnt - open_start : 16'd0;
			made[n].line   = open_line;
			made[n].column = open_col;
			made[n].tbyte  = 8'h00;
			made[n].last   = 1'b0;
			n++;
			scan_st = SCAN_IDLE;
			saw_dot = 1'b0;
		end
		case (cls)
			CLS_END: begin
				made[n].kind   = KIND_END;
				made[n].start  = pos_cnt;
				made[n].length = 16'd0;
				made[n].line   = line_cnt;
				made[n].column = col_cnt;
				made[n].tbyte  = 8'h00;
				made[n].last   = 1'b0;
				n++;
				clear_lexer();
			end
			CLS_SPACE: begin
				step_counters(c);
			end
			CLS_DIGIT, CLS_DOT: begin
				open_token(SCAN_NUMBER);
				saw_dot = (cls == CLS_DOT);
				step_counters(c);
			end
			CLS_LETTER: begin
				open_token(SCAN_IDENT);
				saw_dot = 1'b0;
				step_counters(c);
			end
			default: begin
				// Operators, a lone underscore and every other byte.
				made[n].kind   = single_kind(c);
				made[n].start  = pos_cnt;
				made[n].length = 16'd1;
				made[n].line   = line_cnt;
				made[n].column = col_cnt;
				made[n].tbyte  = c;
				made[n].last   = 1'b0;
				n++;
				step_counters(c);
			end
		endcase
		for (i = 0; i < n; i++) begin
			made[i].last = (i == n - 1);
			token_expect_q.insert(token_expect_q.size(), made[i]);
		end
	endtask

	// Sender: offer the head of the byte queue, hold it until taken, idle in bursts.
	int src_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_bus.valid     <= 1'b0;
			char_bus.char_byte <= CH_END;
			src_gap            <= 0;
			clear_lexer();
		end else begin
			if (char_bus.valid && char_bus.ready) begin
				lex_byte(char_bus.char_byte);
				void'(char_q.pop_front());
			end
			if (char_bus.valid && !char_bus.ready) begin
				// Hold the word until the block takes it.
			end else if (idle_on && src_gap != 0) begin
				char_bus.valid <= 1'b0;
				src_gap        <= src_gap - 1;
			end else if (char_q.size() == 0) begin
				char_bus.valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				// Start an idle burst.
				char_bus.valid <= 1'b0;
				src_gap        <= $urandom_range(0, 10);
			end else begin
				char_bus.valid     <= 1'b1;
				char_bus.char_byte <= char_q[0];
			end
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
	                           input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Receiver: check each taken token against the oldest expectation.
	int     sink_gap;
	int     hold_left;
	int     stalls_served;
	token_t tok_want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_bus.ready <= 1'b0;
			sink_gap        <= 0;
			hold_left       <= 0;
			stalls_served   <= 0;
		end else begin
			if (token_bus.valid && token_bus.ready) begin
				if (token_expect_q.size() == 0) begin
					$display("%0t: unexpected token, expected none, actual kind %0d start %0d",
					         $time, token_bus.token_kind, token_bus.token_start);
					mismatch_count++;
				end else begin
					tok_want = token_expect_q.pop_front();
					check_field("token_kind", 16'(tok_want.kind), 16'(token_bus.token_kind));
					check_field("token_start", tok_want.start, token_bus.token_start);
					check_field("token_length", tok_want.length, token_bus.token_length);
					check_field("token_line", tok_want.line, token_bus.token_line);
					check_field("token_column", tok_want.column, token_bus.token_column);
					check_field("token_byte", 16'(tok_want.tbyte), 16'(token_bus.token_byte));
					check_field("last_of_run", 16'(tok_want.last), 16'(token_bus.last_of_run));
				end
			end
			if (hold_left != 0) begin
				token_bus.ready <= 1'b0;
				hold_left       <= hold_left - 1;
			end else if (stalls_served != stall_requests) begin
				// Long hold-off: let the token queue fill and back up the input.
				token_bus.ready <= 1'b0;
				hold_left       <= LONG_HOLD - 1;
				stalls_served   <= stalls_served + 1;
			end else if (idle_on && sink_gap != 0) begin
				token_bus.ready <= 1'b0;
				sink_gap        <= sink_gap - 1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				token_bus.ready <= 1'b0;
				sink_gap        <= $urandom_range(0, 10);
			end else begin
				token_bus.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no word moves on either side for too long.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_bus.valid && char_bus.ready) || (token_bus.valid && token_bus.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			queue_byte(s[i]);
	endtask

	// Append one random expression: mostly well-formed pieces, some noise.
	task automatic add_expression();
		logic [7:0] op_set[9];
		logic [7:0] ws_set[6];
		int         pieces;
		int         k;
		int         j;
		int         sel;
		int         len;
		int         dot_at;
		op_set = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET,
		           CH_LPAREN, CH_RPAREN, CH_BAR, CH_COMMA};
		ws_set = '{CH_SPACE, CH_TAB, CH_NL, 8'h0B, 8'h0C, CH_CR};
		pieces = $urandom_range(1, 12);
		for (k = 0; k < pieces; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 25) begin
				len    = $urandom_range(1, 4);
				dot_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len) : -1;
				for (j = 0; j < len; j++) begin
					if (j == dot_at) queue_byte(CH_DOT);
					queue_byte(8'(CH_ZERO + $urandom_range(0, 9)));
				end
				if (dot_at == len) queue_byte(CH_DOT);
				// Occasionally one more dot and digit; after an earlier dot this splits the number.
				if ($urandom_range(0, 19) == 0) begin
					queue_byte(CH_DOT);
					queue_byte(8'(CH_ZERO + $urandom_range(0, 9)));
				end
			end else if (sel < 45) begin
				queue_byte(8'(($urandom_range(0, 1) ? CH_UA : CH_LA) + $urandom_range(0, 25)));
				len = $urandom_range(0, 5);
				for (j = 0; j < len; j++) begin
					case ($urandom_range(0, 3))
						0:       queue_byte(8'(CH_UA + $urandom_range(0, 25)));
						1:       queue_byte(8'(CH_LA + $urandom_range(0, 25)));
						2:       queue_byte(8'(CH_ZERO + $urandom_range(0, 9)));
						default: queue_byte(CH_USCORE);
					endcase
				end
			end else if (sel < 75) begin
				queue_byte(op_set[$urandom_range(0, 8)]);
			end else if (sel < 87) begin
				queue_byte(ws_set[$urandom_range(0, 5)]);
			end else begin
				queue_byte(8'($urandom_range(1, 255)));
			end
		end
		// Most expressions close with the end mark; some run into the next.
		if ($urandom_range(0, 9) != 0) queue_byte(CH_END);
	endtask

	// Wait until every queued byte is taken and every token checked.
	task automatic drain();
		while (char_q.size() != 0 || char_bus.valid) @(negedge clk);
		while (token_expect_q.size() != 0) @(negedge clk);
	endtask

	int i;

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: second dot, every operator, lone underscore, high and
		// control bytes, all whitespace, end with and without a pending token.
		push_text("0.9.3+a_9-*(/)^|,_");
		queue_byte(8'h80);
		queue_byte(8'hFF);
		queue_byte(8'h01);
		queue_byte(8'h7F);
		queue_byte(CH_SPACE);
		queue_byte(CH_TAB);
		queue_byte(CH_NL);
		queue_byte(8'h0B);
		queue_byte(8'h0C);
		queue_byte(CH_CR);
		push_text(".Zz");
		queue_byte(CH_END);
		queue_byte(CH_END);
		drain();

		// Back-pressure: receiver holds off while operators keep coming.
		stall_requests = stall_requests + 1;
		for (i = 0; i < 60; i++) queue_byte((i % 2 == 0) ? CH_PLUS : CH_MINUS);
		queue_byte(CH_END);
		drain();

		// Random expressions with idling on both sides.
		while (char_q.size() < 480) add_expression();
		queue_byte(CH_END);
		drain();

		// Last part: full rate on both sides.
		idle_on = 1'b0;
		while (char_q.size() < 80) add_expression();
		queue_byte(CH_END);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && token_expect_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[expression_tokenizer_unit.f]
+incdir+rtl/core
rtl/core/etu_pkg.sv
rtl/core/etu_char_if.sv
rtl/core/etu_token_if.sv
rtl/core/expression_tokenizer_unit.sv
test/tb_top.sv
